// File: rtl/prpe_pkg.sv
// Shared types and constants for the PageRank pass engine.
`timescale 1ns / 1ps
package prpe_pkg;

    localparam int KIND_W = 3;
    localparam int NODE_W = 10;
    localparam int PROB_W = 17;
    localparam int RANK_W = 32;
    localparam int DEV_W  = 64;
    localparam int NCNT_W = 11;
    localparam int DSUM_W = 42;
    localparam int CIDX_W = 2;

    localparam logic [PROB_W-1:0] ONE_Q16 = 17'd65536;

    localparam logic [KIND_W-1:0] KIND_START = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EDGE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DANG  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_END   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

    localparam logic [CIDX_W-1:0] REG_NODE_COUNT = 2'd0;
    localparam logic [CIDX_W-1:0] REG_DAMPING    = 2'd1;
    localparam logic [CIDX_W-1:0] REG_THRESHOLD  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_EDGE_RD,
        ST_EDGE_MUL,
        ST_EDGE_WR,
        ST_DANG_RD,
        ST_DANG_ADD,
        ST_READ_RD,
        ST_READ_OUT,
        ST_DIV,
        ST_WALK,
        ST_RESP
    } state_t;

endpackage

// File: rtl/prpe_ram.sv
// Generic single-write, single-read RAM with registered read (read-first).
`timescale 1ns / 1ps
module prpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: rtl/prpe_div.sv
// Restoring divider, one quotient bit per cycle, for the dangling share.
`timescale 1ns / 1ps
module prpe_div #(
    parameter int NW = 11
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [prpe_pkg::DSUM_W-1:0] dividend,
    input  logic [NW-1:0]             divisor,
    output logic                      done,
    output logic [prpe_pkg::DSUM_W-1:0] quotient
);
    import prpe_pkg::*;

    logic [DSUM_W-1:0] q_reg, q_next;
    logic [NW-1:0]     rem_reg, rem_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [NW:0]       trial;
    logic              fits;

    always_comb begin
        trial     = {rem_reg, q_reg[DSUM_W-1]};
        fits      = trial >= {1'b0, divisor};
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = dividend;
            rem_next  = '0;
            cnt_next  = 6'(DSUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? NW'(trial - {1'b0, divisor}) : trial[NW-1:0];
            q_next   = {q_reg[DSUM_W-2:0], fits};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

// File: rtl/pagerank_pass_engine_unit.sv
// Top level of the PageRank pass engine: control, rank and accumulator memories.
`timescale 1ns / 1ps
// One item at a time: s_ready is high only while the engine is idle, and a finished
// word waits in the output register without blocking the next input. A read or
// dangling item reads the rank, an edge item reads the rank, multiplies and writes
// the accumulator back, and a bad index or unknown kind goes straight to the
// response. A start item sweeps all MAX_NODES entries of both memories, one per
// cycle. An end-of-pass item first divides the dangling sum by the node count,
// then walks all MAX_NODES entries one per cycle through a five-stage update
// pipeline. Ranks read before the first start item are undefined.
module pagerank_pass_engine_unit #(
    parameter int MAX_NODES = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [prpe_pkg::KIND_W-1:0]   s_kind,
    input  logic [prpe_pkg::NODE_W-1:0]   s_source_node,
    input  logic [prpe_pkg::NODE_W-1:0]   s_dest_node,
    input  logic [prpe_pkg::PROB_W-1:0]   s_probability,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [prpe_pkg::RANK_W-1:0]   m_rank_value,
    output logic [prpe_pkg::DEV_W-1:0]    m_deviation,
    output logic                          m_converged,
    output logic                          m_bad_index,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [prpe_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [63:0]                   cfg_data
);
    import prpe_pkg::*;

    localparam int AW = $clog2(MAX_NODES);
    localparam int NW = $clog2(MAX_NODES + 1);

    // configuration
    logic [NCNT_W-1:0] node_count_reg;
    logic [PROB_W-1:0] damping_reg;
    logic [DEV_W-1:0]  threshold_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= 11'd1024;
            damping_reg    <= 17'd55706;
            threshold_reg  <= 64'd429;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_NODE_COUNT: node_count_reg <= cfg_data[NCNT_W-1:0];
                REG_DAMPING:    damping_reg    <= cfg_data[PROB_W-1:0];
                REG_THRESHOLD:  threshold_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // derived configuration
    logic [20:0]       nc_w, lim_w;
    logic [NW-1:0]     live_n;
    logic [PROB_W-1:0] alpha, base;

    always_comb begin
        nc_w = {10'b0, node_count_reg};
        if (nc_w == 21'd0) begin
            lim_w = 21'd1;
        end else if (nc_w > 21'(MAX_NODES)) begin
            lim_w = 21'(MAX_NODES);
        end else begin
            lim_w = nc_w;
        end
        live_n = lim_w[NW-1:0];
        alpha  = (damping_reg > ONE_Q16) ? ONE_Q16 : damping_reg;
        base   = ONE_Q16 - alpha;
    end

    // control state
    state_t state_reg, state_next;
    logic [AW:0]  cnt_reg;
    logic         v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic         m_valid_reg;
    logic         s_fire, out_free;
    logic         walk_issue, fill_last;

    // item and datapath
    logic [NODE_W-1:0] src_reg, dst_reg;
    logic [PROB_W-1:0] prob_reg;
    logic [RANK_W-1:0] res_rank_reg;
    logic [DEV_W-1:0]  res_dev_reg, dev_reg;
    logic              res_conv_reg, res_bad_reg;
    logic [DSUM_W-1:0] dsum_reg;
    logic [48:0]       eprod_reg;
    logic [RANK_W-1:0] ebuf_reg;

    logic [42:0]       sum2_reg;
    logic [RANK_W-1:0] old2_reg, old3_reg;
    logic [AW-1:0]     i1_reg, i2_reg, i3_reg;
    logic              live1_reg, live2_reg, live3_reg;
    logic [59:0]       prod3_reg;
    logic [RANK_W-1:0] d4_reg;
    logic [DEV_W-1:0]  sq5_reg;

    logic [RANK_W-1:0] m_rank_reg;
    logic [DEV_W-1:0]  m_dev_reg;
    logic              m_conv_reg, m_bad_reg;

    // memories
    logic              rk_we, rk_re, ac_we, ac_re;
    logic [AW-1:0]     rk_waddr, rk_raddr, ac_waddr, ac_raddr;
    logic [RANK_W-1:0] rk_wdata, ac_wdata, rk_rdata, ac_rdata;

    prpe_ram #(.WIDTH(RANK_W), .DEPTH(MAX_NODES)) u_rank_ram (
        .aclk  (aclk),
        .we    (rk_we),
        .waddr (rk_waddr),
        .wdata (rk_wdata),
        .re    (rk_re),
        .raddr (rk_raddr),
        .rdata (rk_rdata)
    );

    prpe_ram #(.WIDTH(RANK_W), .DEPTH(MAX_NODES)) u_accum_ram (
        .aclk  (aclk),
        .we    (ac_we),
        .waddr (ac_waddr),
        .wdata (ac_wdata),
        .re    (ac_re),
        .raddr (ac_raddr),
        .rdata (ac_rdata)
    );

    // divider for the dangling share
    logic              div_start, div_done;
    logic [DSUM_W-1:0] share;

    prpe_div #(.NW(NW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dsum_reg),
        .divisor  (live_n),
        .done     (div_done),
        .quotient (share)
    );

    // addresses
    logic [20:0] src_w, dst_w, cnt_w, s_src_w, s_dst_w;
    logic        s_src_bad, s_dst_bad;

    assign src_w    = {11'b0, src_reg};
    assign dst_w    = {11'b0, dst_reg};
    assign cnt_w    = 21'(cnt_reg);
    assign s_src_w  = {11'b0, s_source_node};
    assign s_dst_w  = {11'b0, s_dest_node};
    assign s_src_bad = s_src_w >= 21'(live_n);
    assign s_dst_bad = s_dst_w >= 21'(live_n);

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_fire     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign walk_issue = (state_reg == ST_WALK) && (cnt_reg < (AW+1)'(MAX_NODES));
    assign fill_last  = cnt_reg == (AW+1)'(MAX_NODES - 1);
    assign div_start  = s_fire && (s_kind == KIND_END);

    // walk pipeline arithmetic
    logic [42:0]       sum1;
    logic [44:0]       t3;
    logic [RANK_W-1:0] t3_sat, diff3;
    logic [64:0]       dev_add;
    logic [32:0]       eacc;
    logic [42:0]       dacc;

    always_comb begin
        sum1    = {11'b0, ac_rdata} + {1'b0, share};
        t3      = {1'b0, prod3_reg[59:16]} + 45'(base);
        t3_sat  = (t3 > 45'hFFFF_FFFF) ? 32'hFFFF_FFFF : t3[RANK_W-1:0];
        diff3   = (t3_sat > old3_reg) ? t3_sat - old3_reg : old3_reg - t3_sat;
        dev_add = {1'b0, dev_reg} + {1'b0, sq5_reg};
        eacc    = {1'b0, ebuf_reg} + {1'b0, eprod_reg[47:16]};
        dacc    = {1'b0, dsum_reg} + {11'b0, rk_rdata};
    end

    // memory port control
    always_comb begin
        rk_we    = 1'b0;
        rk_waddr = i3_reg;
        rk_wdata = t3_sat;
        rk_re    = 1'b0;
        rk_raddr = src_w[AW-1:0];
        ac_we    = 1'b0;
        ac_waddr = cnt_reg[AW-1:0];
        ac_wdata = '0;
        ac_re    = 1'b0;
        ac_raddr = dst_w[AW-1:0];
        case (state_reg)
            ST_FILL: begin
                rk_we    = 1'b1;
                rk_waddr = cnt_reg[AW-1:0];
                rk_wdata = 32'(base);
                ac_we    = 1'b1;
            end
            ST_EDGE_RD: begin
                rk_re = 1'b1;
                ac_re = 1'b1;
            end
            ST_EDGE_WR: begin
                ac_we    = 1'b1;
                ac_waddr = dst_w[AW-1:0];
                ac_wdata = eacc[32] ? 32'hFFFF_FFFF : eacc[RANK_W-1:0];
            end
            ST_DANG_RD, ST_READ_RD: begin
                rk_re = 1'b1;
            end
            ST_WALK: begin
                // read-first RAM: clear the accumulator as it is read
                rk_re    = walk_issue;
                rk_raddr = cnt_reg[AW-1:0];
                ac_re    = walk_issue;
                ac_raddr = cnt_reg[AW-1:0];
                ac_we    = walk_issue;
                rk_we    = v3_reg && live3_reg;
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_kind)
                        KIND_START: state_next = ST_FILL;
                        KIND_EDGE:  state_next = (s_src_bad || s_dst_bad) ? ST_RESP
                                                                          : ST_EDGE_RD;
                        KIND_DANG:  state_next = s_src_bad ? ST_RESP : ST_DANG_RD;
                        KIND_END:   state_next = ST_DIV;
                        KIND_READ:  state_next = s_src_bad ? ST_RESP : ST_READ_RD;
                        default:    state_next = ST_RESP;
                    endcase
                end
            end
            ST_FILL:     state_next = fill_last ? ST_RESP : ST_FILL;
            ST_EDGE_RD:  state_next = ST_EDGE_MUL;
            ST_EDGE_MUL: state_next = ST_EDGE_WR;
            ST_EDGE_WR:  state_next = ST_RESP;
            ST_DANG_RD:  state_next = ST_DANG_ADD;
            ST_DANG_ADD: state_next = ST_RESP;
            ST_READ_RD:  state_next = ST_READ_OUT;
            ST_READ_OUT: state_next = ST_RESP;
            ST_DIV:      state_next = div_done ? ST_WALK : ST_DIV;
            ST_WALK: begin
                if (!walk_issue && !v1_reg && !v2_reg && !v3_reg && !v4_reg && !v5_reg) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:     state_next = out_free ? ST_IDLE : ST_RESP;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            dsum_reg    <= '0;
        end else begin
            if (s_fire) begin
                cnt_reg <= '0;
            end else if (state_reg == ST_FILL || walk_issue) begin
                cnt_reg <= cnt_reg + (AW+1)'(1);
            end
            v1_reg <= walk_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            if (state_reg == ST_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_FILL) begin
                dsum_reg <= '0;
            end else if (state_reg == ST_DANG_ADD) begin
                dsum_reg <= dacc[42] ? {DSUM_W{1'b1}} : dacc[DSUM_W-1:0];
            end else if (state_reg == ST_WALK && state_next == ST_RESP) begin
                dsum_reg <= '0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            src_reg      <= s_source_node;
            dst_reg      <= s_dest_node;
            prob_reg     <= (s_probability > ONE_Q16) ? ONE_Q16 : s_probability;
            res_rank_reg <= '0;
            res_dev_reg  <= '0;
            res_conv_reg <= 1'b0;
            res_bad_reg  <= ((s_kind == KIND_EDGE) && (s_src_bad || s_dst_bad)) ||
                            ((s_kind == KIND_DANG || s_kind == KIND_READ) && s_src_bad);
            dev_reg      <= '0;
        end
        if (state_reg == ST_EDGE_MUL) begin
            eprod_reg <= {17'b0, rk_rdata} * {32'b0, prob_reg};
            ebuf_reg  <= ac_rdata;
        end
        if (state_reg == ST_READ_OUT) begin
            res_rank_reg <= rk_rdata;
        end
        // walk pipeline
        i1_reg    <= cnt_reg[AW-1:0];
        live1_reg <= cnt_w < 21'(live_n);
        sum2_reg  <= sum1;
        old2_reg  <= rk_rdata;
        i2_reg    <= i1_reg;
        live2_reg <= live1_reg;
        prod3_reg <= {17'b0, sum2_reg} * {43'b0, alpha};
        old3_reg  <= old2_reg;
        i3_reg    <= i2_reg;
        live3_reg <= live2_reg;
        d4_reg    <= live3_reg ? diff3 : '0;
        sq5_reg   <= {32'b0, d4_reg} * {32'b0, d4_reg};
        if (v5_reg) begin
            dev_reg <= dev_add[64] ? {DEV_W{1'b1}} : dev_add[DEV_W-1:0];
        end
        if (state_reg == ST_WALK && state_next == ST_RESP) begin
            res_dev_reg  <= dev_reg;
            res_conv_reg <= dev_reg < threshold_reg;
        end
        // output word
        if (state_reg == ST_RESP && out_free) begin
            m_rank_reg <= res_rank_reg;
            m_dev_reg  <= res_dev_reg;
            m_conv_reg <= res_conv_reg;
            m_bad_reg  <= res_bad_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_rank_value = m_rank_reg;
    assign m_deviation  = m_dev_reg;
    assign m_converged  = m_conv_reg;
    assign m_bad_index  = m_bad_reg;
endmodule

// File: rtl/prpe_checker.sv
// Port-level checks for the PageRank pass engine, bound to the top level.
`timescale 1ns / 1ps
module prpe_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [prpe_pkg::RANK_W-1:0] m_rank_value,
    input logic [prpe_pkg::DEV_W-1:0]  m_deviation,
    input logic                        m_converged,
    input logic                        m_bad_index
);
    import prpe_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped before it was taken");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in progress");

    a_bad_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_index |-> m_rank_value == '0 && m_deviation == '0 && !m_converged)
        else $error("skipped item carries data");

    a_conv_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_converged |-> !m_bad_index && m_rank_value == '0)
        else $error("converged flag on a non end-of-pass word");
endmodule

bind pagerank_pass_engine_unit prpe_checker u_prpe_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_rank_value (m_rank_value),
    .m_deviation  (m_deviation),
    .m_converged  (m_converged),
    .m_bad_index  (m_bad_index)
);
